[rtl/dllc_pkg.sv]
`default_nettype none

package dllc_pkg;

	// Default sizing of the node pool
	localparam int DEF_NODES        = 16;
	localparam int DEF_PAYLOAD_BITS = 32;

	localparam int ACTION_W = 4;
	localparam int STATUS_W = 2;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_FIRST     = 4'd0;
	localparam logic [ACTION_W-1:0] ACT_NEXT      = 4'd1;
	localparam logic [ACTION_W-1:0] ACT_LAST      = 4'd2;
	localparam logic [ACTION_W-1:0] ACT_PREV      = 4'd3;
	localparam logic [ACTION_W-1:0] ACT_PUSH_HEAD = 4'd4;
	localparam logic [ACTION_W-1:0] ACT_PUSH_TAIL = 4'd5;
	localparam logic [ACTION_W-1:0] ACT_PUSH_CUR  = 4'd6;
	localparam logic [ACTION_W-1:0] ACT_POP_HEAD  = 4'd7;
	localparam logic [ACTION_W-1:0] ACT_POP_TAIL  = 4'd8;
	localparam logic [ACTION_W-1:0] ACT_POP_CUR   = 4'd9;
	localparam logic [ACTION_W-1:0] ACT_CLEAR     = 4'd10;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NO_CURSOR = 2'd3;

	// Write enables from the step logic to the node pool
	typedef struct packed {
		logic fwd0;
		logic fwd1;
		logic bwd0;
		logic bwd1;
		logic pay;
		logic take;
	} dllc_we_t;

endpackage

`default_nettype wire

[rtl/dllc_pool.sv]
`default_nettype none

module dllc_pool #(
	parameter int NODES        = dllc_pkg::DEF_NODES,
	parameter int PAYLOAD_BITS = dllc_pkg::DEF_PAYLOAD_BITS
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire  [$clog2(NODES+1)-1:0]          a_idx,
	input  wire  [$clog2(NODES+1)-1:0]          b_idx,
	input  wire  [$clog2(NODES+1)-1:0]          f_idx,
	output logic [$clog2(NODES+1)-1:0]          a_fwd,
	output logic [$clog2(NODES+1)-1:0]          a_bwd,
	output logic [$clog2(NODES+1)-1:0]          b_fwd,
	output logic [$clog2(NODES+1)-1:0]          b_bwd,
	output logic [PAYLOAD_BITS-1:0]             b_pay,
	output logic [$clog2(NODES+1)-1:0]          f_fwd,
	input  dllc_pkg::dllc_we_t                  we,
	input  wire  [$clog2(NODES+1)-1:0]          fwd0_idx,
	input  wire  [$clog2(NODES+1)-1:0]          fwd0_data,
	input  wire  [$clog2(NODES+1)-1:0]          fwd1_idx,
	input  wire  [$clog2(NODES+1)-1:0]          fwd1_data,
	input  wire  [$clog2(NODES+1)-1:0]          bwd0_idx,
	input  wire  [$clog2(NODES+1)-1:0]          bwd0_data,
	input  wire  [$clog2(NODES+1)-1:0]          bwd1_idx,
	input  wire  [$clog2(NODES+1)-1:0]          bwd1_data,
	input  wire  [$clog2(NODES+1)-1:0]          pay_idx,
	input  wire  [PAYLOAD_BITS-1:0]             pay_data
);

	localparam int IW = $clog2(NODES + 1);
	localparam int AW = $clog2(NODES);

	logic [IW-1:0]           fwd_mem [NODES];
	logic [IW-1:0]           bwd_mem [NODES];
	logic [PAYLOAD_BITS-1:0] pay_mem [NODES];

	// Nodes at or above the mark were never taken and still hold the reset free chain
	logic [IW-1:0] hwm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hwm_q <= '0;
		end else if (we.take && (f_idx == hwm_q)) begin
			hwm_q <= hwm_q + IW'(1);
		end
	end

	// Update node links and payloads
	always_ff @(posedge clk) begin
		if (we.fwd0) begin
			fwd_mem[fwd0_idx[AW-1:0]] <= fwd0_data;
		end
		if (we.fwd1) begin
			fwd_mem[fwd1_idx[AW-1:0]] <= fwd1_data;
		end
		if (we.bwd0) begin
			bwd_mem[bwd0_idx[AW-1:0]] <= bwd0_data;
		end
		if (we.bwd1) begin
			bwd_mem[bwd1_idx[AW-1:0]] <= bwd1_data;
		end
		if (we.pay) begin
			pay_mem[pay_idx[AW-1:0]] <= pay_data;
		end
	end

	// Read ports: cursor, target and free head
	always_comb begin
		a_fwd = (a_idx >= hwm_q) ? a_idx + IW'(1) : fwd_mem[a_idx[AW-1:0]];
		b_fwd = (b_idx >= hwm_q) ? b_idx + IW'(1) : fwd_mem[b_idx[AW-1:0]];
		f_fwd = (f_idx >= hwm_q) ? f_idx + IW'(1) : fwd_mem[f_idx[AW-1:0]];
		a_bwd = bwd_mem[a_idx[AW-1:0]];
		b_bwd = bwd_mem[b_idx[AW-1:0]];
		b_pay = pay_mem[b_idx[AW-1:0]];
	end

endmodule

`default_nettype wire

[rtl/dllc_step.sv]
`default_nettype none

module dllc_step #(
	parameter int NODES        = dllc_pkg::DEF_NODES,
	parameter int PAYLOAD_BITS = dllc_pkg::DEF_PAYLOAD_BITS
) (
	input  wire  [dllc_pkg::ACTION_W-1:0]       action,
	input  wire  [PAYLOAD_BITS-1:0]             payload,
	input  wire  [$clog2(NODES+1)-1:0]          first_cur,
	input  wire  [$clog2(NODES+1)-1:0]          last_cur,
	input  wire  [$clog2(NODES+1)-1:0]          cursor_cur,
	input  wire  [$clog2(NODES+1)-1:0]          free_cur,
	input  wire  [$clog2(NODES+1)-1:0]          used_cur,
	input  wire  [$clog2(NODES+1)-1:0]          a_fwd,
	input  wire  [$clog2(NODES+1)-1:0]          a_bwd,
	input  wire  [$clog2(NODES+1)-1:0]          b_fwd,
	input  wire  [$clog2(NODES+1)-1:0]          b_bwd,
	input  wire  [PAYLOAD_BITS-1:0]             b_pay,
	input  wire  [$clog2(NODES+1)-1:0]          f_fwd,
	output logic [$clog2(NODES+1)-1:0]          b_idx,
	output logic [$clog2(NODES+1)-1:0]          first_nx,
	output logic [$clog2(NODES+1)-1:0]          last_nx,
	output logic [$clog2(NODES+1)-1:0]          cursor_nx,
	output logic [$clog2(NODES+1)-1:0]          free_nx,
	output logic [$clog2(NODES+1)-1:0]          used_nx,
	output dllc_pkg::dllc_we_t                  we,
	output logic [$clog2(NODES+1)-1:0]          fwd0_idx,
	output logic [$clog2(NODES+1)-1:0]          fwd0_data,
	output logic [$clog2(NODES+1)-1:0]          fwd1_idx,
	output logic [$clog2(NODES+1)-1:0]          fwd1_data,
	output logic [$clog2(NODES+1)-1:0]          bwd0_idx,
	output logic [$clog2(NODES+1)-1:0]          bwd0_data,
	output logic [$clog2(NODES+1)-1:0]          bwd1_idx,
	output logic [$clog2(NODES+1)-1:0]          bwd1_data,
	output logic [$clog2(NODES+1)-1:0]          pay_idx,
	output logic [PAYLOAD_BITS-1:0]             pay_data,
	output logic [PAYLOAD_BITS-1:0]             value,
	output logic                                has_value,
	output logic [dllc_pkg::STATUS_W-1:0]       status
);

	localparam int            IW   = $clog2(NODES + 1);
	localparam logic [IW-1:0] NONE = IW'(NODES);

	logic          cur_ok;
	logic          tgt_ok;
	logic          full;
	logic          empty;
	logic          nx_ok;
	logic          pv_ok;
	logic [IW-1:0] n;

	// Pick the node that a move or a pop looks at
	always_comb begin
		cur_ok = (cursor_cur < NONE);
		case (action)
			dllc_pkg::ACT_FIRST, dllc_pkg::ACT_POP_HEAD: b_idx = first_cur;
			dllc_pkg::ACT_LAST,  dllc_pkg::ACT_POP_TAIL: b_idx = last_cur;
			dllc_pkg::ACT_NEXT:    b_idx = cur_ok ? a_fwd : NONE;
			dllc_pkg::ACT_PREV:    b_idx = cur_ok ? a_bwd : NONE;
			dllc_pkg::ACT_POP_CUR: b_idx = cursor_cur;
			default:               b_idx = NONE;
		endcase
	end

	// Compute next list state, node writes and the result
	always_comb begin
		tgt_ok = (b_idx < NONE);
		full   = !(free_cur < NONE);
		empty  = !(first_cur < NONE);
		nx_ok  = (b_fwd < NONE);
		pv_ok  = (b_bwd < NONE);
		n      = free_cur;

		first_nx  = first_cur;
		last_nx   = last_cur;
		cursor_nx = cursor_cur;
		free_nx   = free_cur;
		used_nx   = used_cur;
		we        = '0;
		fwd0_idx  = n;
		fwd0_data = NONE;
		fwd1_idx  = NONE;
		fwd1_data = NONE;
		bwd0_idx  = n;
		bwd0_data = NONE;
		bwd1_idx  = NONE;
		bwd1_data = NONE;
		pay_idx   = n;
		pay_data  = payload;
		value     = '0;
		has_value = 1'b0;
		status    = dllc_pkg::ST_OK;

		case (action)
			dllc_pkg::ACT_FIRST, dllc_pkg::ACT_LAST,
			dllc_pkg::ACT_NEXT, dllc_pkg::ACT_PREV: begin
				if (tgt_ok) begin
					cursor_nx = b_idx;
					value     = b_pay;
					has_value = 1'b1;
				end else begin
					status = dllc_pkg::ST_EMPTY;
				end
			end

			dllc_pkg::ACT_PUSH_HEAD, dllc_pkg::ACT_PUSH_TAIL, dllc_pkg::ACT_PUSH_CUR: begin
				if ((action == dllc_pkg::ACT_PUSH_CUR) && !cur_ok) begin
					status = dllc_pkg::ST_NO_CURSOR;
				end else if (full) begin
					status = dllc_pkg::ST_FULL;
				end else begin
					// Take the free head and fill it
					we.take  = 1'b1;
					we.pay   = 1'b1;
					we.fwd0  = 1'b1;
					we.bwd0  = 1'b1;
					free_nx  = f_fwd;
					used_nx  = used_cur + IW'(1);
					if (action == dllc_pkg::ACT_PUSH_TAIL) begin
						cursor_nx = last_cur;
					end
					if (action == dllc_pkg::ACT_PUSH_CUR) begin
						// Link after the cursor
						fwd0_data = a_fwd;
						bwd0_data = cursor_cur;
						we.fwd1   = 1'b1;
						fwd1_idx  = cursor_cur;
						fwd1_data = n;
						if (a_fwd < NONE) begin
							we.bwd1   = 1'b1;
							bwd1_idx  = a_fwd;
							bwd1_data = n;
						end else begin
							last_nx = n;
						end
					end else if (empty) begin
						first_nx = n;
						last_nx  = n;
					end else if (action == dllc_pkg::ACT_PUSH_HEAD) begin
						fwd0_data = first_cur;
						we.bwd1   = 1'b1;
						bwd1_idx  = first_cur;
						bwd1_data = n;
						first_nx  = n;
					end else begin
						// Link after the tail
						bwd0_data = last_cur;
						we.fwd1   = 1'b1;
						fwd1_idx  = last_cur;
						fwd1_data = n;
						last_nx   = n;
					end
				end
			end

			dllc_pkg::ACT_POP_HEAD, dllc_pkg::ACT_POP_TAIL, dllc_pkg::ACT_POP_CUR: begin
				if (tgt_ok) begin
					value     = b_pay;
					has_value = 1'b1;
					// Return the node to the free list
					we.fwd0   = 1'b1;
					fwd0_idx  = b_idx;
					fwd0_data = free_cur;
					free_nx   = b_idx;
					if (used_cur != '0) begin
						used_nx = used_cur - IW'(1);
					end
					if ((first_cur == b_idx) && (last_cur == b_idx)) begin
						first_nx  = NONE;
						last_nx   = NONE;
						cursor_nx = NONE;
					end else if (first_cur == b_idx) begin
						first_nx  = b_fwd;
						cursor_nx = b_fwd;
						we.bwd1   = nx_ok;
						bwd1_idx  = b_fwd;
						bwd1_data = NONE;
					end else if (last_cur == b_idx) begin
						last_nx   = b_bwd;
						cursor_nx = NONE;
						we.fwd1   = pv_ok;
						fwd1_idx  = b_bwd;
						fwd1_data = NONE;
					end else begin
						cursor_nx = b_fwd;
						we.fwd1   = pv_ok;
						fwd1_idx  = b_bwd;
						fwd1_data = b_fwd;
						we.bwd1   = nx_ok;
						bwd1_idx  = b_fwd;
						bwd1_data = b_bwd;
					end
				end else begin
					status    = dllc_pkg::ST_EMPTY;
					cursor_nx = b_idx;
				end
			end

			dllc_pkg::ACT_CLEAR: begin
				// Splice the whole list onto the free list
				if (!empty && (last_cur < NONE)) begin
					we.fwd0   = 1'b1;
					fwd0_idx  = last_cur;
					fwd0_data = free_cur;
					free_nx   = first_cur;
					first_nx  = NONE;
					last_nx   = NONE;
					cursor_nx = NONE;
					used_nx   = '0;
				end
			end

			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/doubly_linked_list_cursor.sv]
`default_nettype none

// Channel   Direction  Transaction
// s_*       in         action [3:0], payload above it in tdata
// m_*       out        value in tdata; has_value, status in tuser
//
// One action per cycle while the output is not stalled: an accepted transaction is held in the input stage
// and its result is registered in the result register when it advances.
// All list and node reads and writes for an action happen in the same cycle over the
// flop pool; the free-chain reset needs no clearing pass (a fill mark covers it).
// Reset empties the list and drops both stages.
// A stalled output holds the result and the input stage, and s_tready falls while the input stage is full.

module doubly_linked_list_cursor #(
	parameter int NODES        = dllc_pkg::DEF_NODES,
	parameter int PAYLOAD_BITS = dllc_pkg::DEF_PAYLOAD_BITS
) (
	input  wire                                                clk,
	input  wire                                                arst_n,
	input  wire                                                s_tvalid,
	output logic                                               s_tready,
	// action, payload
	input  wire  [((dllc_pkg::ACTION_W+PAYLOAD_BITS+7)/8)*8-1:0] s_tdata,
	output logic                                               m_tvalid,
	input  wire                                                m_tready,
	// value
	output logic [((PAYLOAD_BITS+7)/8)*8-1:0]                  m_tdata,
	// has_value, status
	output logic [dllc_pkg::STATUS_W:0]                        m_tuser
);

	localparam int            IW   = $clog2(NODES + 1);
	localparam logic [IW-1:0] NONE = IW'(NODES);

	// Input stage
	logic                              valid_s1;
	logic [dllc_pkg::ACTION_W-1:0]     action_s1;
	logic [PAYLOAD_BITS-1:0]           payload_s1;

	// List state
	logic [IW-1:0] first_q, last_q, cursor_q, free_q, used_q;

	// Result register
	logic                              out_valid_q;
	logic [PAYLOAD_BITS-1:0]           value_q;
	logic                              has_q;
	logic [dllc_pkg::STATUS_W-1:0]     status_q;

	logic                              advance;

	logic [IW-1:0]                     a_fwd, a_bwd, b_fwd, b_bwd, f_fwd, b_idx;
	logic [PAYLOAD_BITS-1:0]           b_pay;
	logic [IW-1:0]                     first_nx, last_nx, cursor_nx, free_nx, used_nx;
	dllc_pkg::dllc_we_t                we;
	logic [IW-1:0]                     fwd0_idx, fwd0_data, fwd1_idx, fwd1_data;
	logic [IW-1:0]                     bwd0_idx, bwd0_data, bwd1_idx, bwd1_data;
	logic [IW-1:0]                     pay_idx;
	logic [PAYLOAD_BITS-1:0]           pay_data;
	logic [PAYLOAD_BITS-1:0]           value_nx;
	logic                              has_nx;
	logic [dllc_pkg::STATUS_W-1:0]     status_nx;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Capture the incoming transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1  <= s_tdata[dllc_pkg::ACTION_W-1:0];
			payload_s1 <= s_tdata[dllc_pkg::ACTION_W +: PAYLOAD_BITS];
		end
	end

	dllc_pool #(
		.NODES        (NODES),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_pool (
		.clk       (clk),
		.arst_n    (arst_n),
		.a_idx     (cursor_q),
		.b_idx     (b_idx),
		.f_idx     (free_q),
		.a_fwd     (a_fwd),
		.a_bwd     (a_bwd),
		.b_fwd     (b_fwd),
		.b_bwd     (b_bwd),
		.b_pay     (b_pay),
		.f_fwd     (f_fwd),
		.we        (advance ? we : '0),
		.fwd0_idx  (fwd0_idx),
		.fwd0_data (fwd0_data),
		.fwd1_idx  (fwd1_idx),
		.fwd1_data (fwd1_data),
		.bwd0_idx  (bwd0_idx),
		.bwd0_data (bwd0_data),
		.bwd1_idx  (bwd1_idx),
		.bwd1_data (bwd1_data),
		.pay_idx   (pay_idx),
		.pay_data  (pay_data)
	);

	dllc_step #(
		.NODES        (NODES),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_step (
		.action     (action_s1),
		.payload    (payload_s1),
		.first_cur  (first_q),
		.last_cur   (last_q),
		.cursor_cur (cursor_q),
		.free_cur   (free_q),
		.used_cur   (used_q),
		.a_fwd      (a_fwd),
		.a_bwd      (a_bwd),
		.b_fwd      (b_fwd),
		.b_bwd      (b_bwd),
		.b_pay      (b_pay),
		.f_fwd      (f_fwd),
		.b_idx      (b_idx),
		.first_nx   (first_nx),
		.last_nx    (last_nx),
		.cursor_nx  (cursor_nx),
		.free_nx    (free_nx),
		.used_nx    (used_nx),
		.we         (we),
		.fwd0_idx   (fwd0_idx),
		.fwd0_data  (fwd0_data),
		.fwd1_idx   (fwd1_idx),
		.fwd1_data  (fwd1_data),
		.bwd0_idx   (bwd0_idx),
		.bwd0_data  (bwd0_data),
		.bwd1_idx   (bwd1_idx),
		.bwd1_data  (bwd1_data),
		.pay_idx    (pay_idx),
		.pay_data   (pay_data),
		.value      (value_nx),
		.has_value  (has_nx),
		.status     (status_nx)
	);

	// Advance the list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= NONE;
			last_q   <= NONE;
			cursor_q <= NONE;
			free_q   <= '0;
			used_q   <= '0;
		end else if (advance) begin
			first_q  <= first_nx;
			last_q   <= last_nx;
			cursor_q <= cursor_nx;
			free_q   <= free_nx;
			used_q   <= used_nx;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			value_q  <= value_nx;
			has_q    <= has_nx;
			status_q <= status_nx;
		end
	end

	always_comb begin
		m_tvalid               = out_valid_q;
		m_tdata                = '0;
		m_tdata[PAYLOAD_BITS-1:0] = value_q;
		m_tuser                = {status_q, has_q};
	end

	// List consistency checks
	a_count_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q == '0) == (first_q == NONE))
		else $error("element count disagrees with list head");

	a_head_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(first_q == NONE) == (last_q == NONE))
		else $error("head and tail disagree on empty list");

	a_cursor_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(first_q == NONE) |-> (cursor_q == NONE))
		else $error("cursor set on empty list");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(free_q == NONE) == (used_q == IW'(NODES)))
		else $error("free list exhausted with spare nodes");

endmodule

`default_nettype wire
